### hw/rtl/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg
// Types and constants shared by the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned CP_W    = 21;

  localparam logic [CNT_W-1:0] SEQ_MAX  = 3'd4;
  localparam logic [CP_W-1:0]  CP_LIMIT = 21'h10FFFF;

  // Lead byte classes
  localparam logic [BYTE_W-1:0] LEAD_MIN   = 8'hC0;
  localparam logic [1:0]        CONT_TAG   = 2'b10;

  localparam logic [CNT_W-1:0] LEN_ZERO  = 3'd0;
  localparam logic [CNT_W-1:0] LEN_ONE   = 3'd1;
  localparam logic [CNT_W-1:0] LEN_TWO   = 3'd2;
  localparam logic [CNT_W-1:0] LEN_THREE = 3'd3;
  localparam logic [CNT_W-1:0] LEN_FOUR  = 3'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_zero;
    logic [BYTE_W-1:0] byte_one;
    logic [BYTE_W-1:0] byte_two;
    logic [BYTE_W-1:0] byte_three;
    logic [CNT_W-1:0]  avail_count;
  } dec_in_t;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [CNT_W-1:0] consumed;
  } dec_res_t;

endpackage

### hw/rtl/u8dec_decode.sv
// ----------------------------------------------------------------------------
// u8dec_decode
// Combinational decode of one UTF-8 sequence from a four byte window.
// ----------------------------------------------------------------------------
module u8dec_decode (
  input  u8dec_pkg::dec_in_t  win_i,
  output u8dec_pkg::dec_res_t res_o
);
  import u8dec_pkg::*;

  logic [CNT_W-1:0] avail;
  logic [CNT_W-1:0] seq_len;
  logic             cont1_ok;
  logic             cont2_ok;
  logic             cont3_ok;
  logic [CP_W-1:0]  val2;
  logic [CP_W-1:0]  val3;
  logic [CP_W-1:0]  val4;
  logic [CP_W-1:0]  lead_cp;

  assign avail   = (win_i.avail_count > SEQ_MAX) ? SEQ_MAX : win_i.avail_count;
  assign lead_cp = {{(CP_W-BYTE_W){1'b0}}, win_i.byte_zero};

  assign cont1_ok = (win_i.byte_one[7:6]   == CONT_TAG);
  assign cont2_ok = (win_i.byte_two[7:6]   == CONT_TAG);
  assign cont3_ok = (win_i.byte_three[7:6] == CONT_TAG);

  assign val2 = {10'd0, win_i.byte_zero[4:0], win_i.byte_one[5:0]};
  assign val3 = {5'd0, win_i.byte_zero[3:0], win_i.byte_one[5:0], win_i.byte_two[5:0]};
  assign val4 = {win_i.byte_zero[2:0], win_i.byte_one[5:0], win_i.byte_two[5:0],
                 win_i.byte_three[5:0]};

  // run of ones in the lead byte; zero means fewer than two or more than four
  always_comb begin
    unique casez (win_i.byte_zero)
      8'b110?_????: seq_len = LEN_TWO;
      8'b1110_????: seq_len = LEN_THREE;
      8'b1111_0???: seq_len = LEN_FOUR;
      default:      seq_len = LEN_ZERO;
    endcase
  end

  always_comb begin
    res_o.code_point = lead_cp;
    res_o.consumed   = LEN_ONE;
    if (avail == LEN_ZERO) begin
      res_o.code_point = '0;
      res_o.consumed   = LEN_ZERO;
    end else if (win_i.byte_zero >= LEAD_MIN && seq_len != LEN_ZERO && seq_len <= avail) begin
      unique case (seq_len)
        LEN_TWO: begin
          if (cont1_ok) begin
            res_o.code_point = val2;
            res_o.consumed   = LEN_TWO;
          end
        end
        LEN_THREE: begin
          if (cont1_ok && cont2_ok) begin
            res_o.code_point = val3;
            res_o.consumed   = LEN_THREE;
          end
        end
        LEN_FOUR: begin
          if (cont1_ok && cont2_ok && cont3_ok && val4 <= CP_LIMIT) begin
            res_o.code_point = val4;
            res_o.consumed   = LEN_FOUR;
          end
        end
        default: begin
          res_o.code_point = lead_cp;
          res_o.consumed   = LEN_ONE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/utf8_code_point_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_code_point_decoder_unit
// Decodes one UTF-8 sequence per beat into a code point and byte count.
// ----------------------------------------------------------------------------
// Each input beat carries a four byte window and the count of valid bytes
// from the lead byte; each yields exactly one result beat with the code point
// and the number of bytes consumed (0 when no byte is available, 1 on a
// Latin-1 fallback). The window is captured in an input register, decoded
// by a shallow single-pass logic cone, and held in the result register.
// Throughput is one beat per clock; in_ready drops only when both
// registers are full and out_ready is low.
module utf8_code_point_decoder_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [u8dec_pkg::BYTE_W-1:0]  in_byte_zero,
  input  logic [u8dec_pkg::BYTE_W-1:0]  in_byte_one,
  input  logic [u8dec_pkg::BYTE_W-1:0]  in_byte_two,
  input  logic [u8dec_pkg::BYTE_W-1:0]  in_byte_three,
  input  logic [u8dec_pkg::CNT_W-1:0]   in_avail_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [u8dec_pkg::CP_W-1:0]    out_code_point,
  output logic [u8dec_pkg::CNT_W-1:0]   out_consumed
);
  import u8dec_pkg::*;

  logic     stg_vld_r, stg_vld_nxt;
  dec_in_t  stg_win_r;
  logic     res_vld_r, res_vld_nxt;
  dec_res_t res_r;
  dec_res_t dec_res;
  logic     res_free;
  logic     stg_adv;
  logic     in_take;

  assign res_free = !res_vld_r || out_ready;
  assign stg_adv  = stg_vld_r && res_free;
  assign in_ready = !stg_vld_r || res_free;
  assign in_take  = in_valid && in_ready;

  u8dec_decode u_decode (
    .win_i (stg_win_r),
    .res_o (dec_res)
  );

  assign stg_vld_nxt = in_take ? 1'b1 : (stg_adv ? 1'b0 : stg_vld_r);
  assign res_vld_nxt = stg_adv ? 1'b1 : (out_ready ? 1'b0 : res_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_win_r.byte_zero   <= in_byte_zero;
      stg_win_r.byte_one    <= in_byte_one;
      stg_win_r.byte_two    <= in_byte_two;
      stg_win_r.byte_three  <= in_byte_three;
      stg_win_r.avail_count <= in_avail_count;
    end
    if (stg_adv) begin
      res_r <= dec_res;
    end
  end

  assign out_valid      = res_vld_r;
  assign out_code_point = res_r.code_point;
  assign out_consumed   = res_r.consumed;

  a_cp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_code_point <= CP_LIMIT)
    else $error("code point above limit");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_consumed <= SEQ_MAX)
    else $error("consumed count out of range");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_consumed == LEN_ZERO) |-> out_code_point == '0)
    else $error("empty window gave nonzero code point");

  a_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_consumed == LEN_ONE) |-> out_code_point[CP_W-1:BYTE_W] == '0)
    else $error("single byte result wider than a byte");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_vld_r && !res_free) |=> stg_vld_r)
    else $error("stalled beat dropped from input register");

endmodule
